// ===== design/utf8_stream_decoder_assert.svh =====
// assertion macros for the utf8 stream decoder
// expects clk and arst_n in the scope of each use
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

// same-cycle implication
`define U8SD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define U8SD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/u8sd_pkg.sv =====
// types and constants for the utf8 stream decoder
// no dependencies
`timescale 1ns / 1ps

package u8sd_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned CodeW = 21;
	localparam int unsigned PendW = 2;

	localparam logic [ByteW-1:0] LEAD2_MIN = 8'hC0;
	localparam logic [ByteW-1:0] LEAD3_MIN = 8'hE0;
	localparam logic [ByteW-1:0] LEAD4_MIN = 8'hF0;
	localparam logic [ByteW-1:0] LEAD_BAD_MIN = 8'hF8;
	localparam logic [ByteW-1:0] CONT_MARK = 8'h80;

	localparam logic [CodeW-1:0] MAX1 = 21'h00007F;
	localparam logic [CodeW-1:0] MAX2 = 21'h0007FF;
	localparam logic [CodeW-1:0] MAX3 = 21'h00FFFF;

	localparam logic [PendW-1:0] PEND_IDLE = 2'd0;
	localparam logic [PendW-1:0] PEND_ONE = 2'd1;
	localparam logic [PendW-1:0] PEND_TWO = 2'd2;
	localparam logic [PendW-1:0] PEND_THREE = 2'd3;

	typedef struct packed {
		logic [ByteW-1:0] text_byte;
		logic             final_byte;
	} in_item_t;

	typedef struct packed {
		logic [CodeW-1:0] code_point;
		logic             bad_sequence;
		logic             string_end;
	} out_item_t;

endpackage

// ===== design/u8sd_chan_if.sv =====
// valid/ready channel carrying one request payload
// payload type comes from u8sd_pkg at the point of use
`timescale 1ns / 1ps

interface u8sd_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== design/utf8_stream_decoder.sv =====
// utf8 stream decoder top level: input register, decode state, result register
// depends on u8sd_pkg, u8sd_chan_if and utf8_stream_decoder_assert.svh
`timescale 1ns / 1ps

// A byte lands in the input register, is decoded there against the group state,
// and its result (if it makes one) is then written to the result register when that
// register is empty or being taken. The sustained rate is one byte per cycle while
// the result side keeps taking requests. The group state update in the input stage
// sets that rate: each byte needs the state the byte before it left.

`include "utf8_stream_decoder_assert.svh"

module utf8_stream_decoder (
	input logic clk,
	input logic arst_n,
	u8sd_chan_if.sink   in,
	u8sd_chan_if.source out
);

	logic                        valid_s1;
	u8sd_pkg::in_item_t          item_s1;
	logic                        out_valid_q;
	u8sd_pkg::out_item_t         out_item_q;

	logic [u8sd_pkg::ByteW-1:0]  lead_q;
	logic [u8sd_pkg::CodeW-1:0]  gathered_q;
	logic [u8sd_pkg::PendW-1:0]  pending_q;
	logic                        broken_q;

	logic [u8sd_pkg::ByteW-1:0]  lead_n;
	logic [u8sd_pkg::CodeW-1:0]  gathered_n;
	logic [u8sd_pkg::PendW-1:0]  pending_n;
	logic                        broken_n;

	logic                        adv_s1;
	logic                        emit;
	logic                        bad;
	logic [u8sd_pkg::CodeW-1:0]  code;
	logic [u8sd_pkg::ByteW-1:0]  b;
	logic [u8sd_pkg::ByteW-1:0]  c;
	logic                        fin;

	assign adv_s1 = !out_valid_q || out.ready;
	assign in.ready = !valid_s1 || adv_s1;
	assign out.valid = out_valid_q;
	assign out.payload = out_item_q;

	assign b = item_s1.text_byte;
	assign fin = item_s1.final_byte;
	assign c = b ^ u8sd_pkg::CONT_MARK;

	always_comb begin
		lead_n = lead_q;
		gathered_n = gathered_q;
		pending_n = pending_q;
		broken_n = broken_q;
		emit = 1'b0;
		bad = 1'b0;
		code = '0;
		if (pending_q == u8sd_pkg::PEND_IDLE) begin
			if (!b[7]) begin
				emit = 1'b1;
				code = {{(u8sd_pkg::CodeW-u8sd_pkg::ByteW){1'b0}}, b};
			end else if (b < u8sd_pkg::LEAD2_MIN) begin
				emit = 1'b1;
				bad = 1'b1;
			end else begin
				lead_n = b;
				gathered_n = {{(u8sd_pkg::CodeW-u8sd_pkg::ByteW){1'b0}}, b};
				if (b < u8sd_pkg::LEAD3_MIN) begin
					pending_n = u8sd_pkg::PEND_ONE;
				end else if (b < u8sd_pkg::LEAD4_MIN) begin
					pending_n = u8sd_pkg::PEND_TWO;
				end else begin
					pending_n = u8sd_pkg::PEND_THREE;
				end
				broken_n = (b >= u8sd_pkg::LEAD_BAD_MIN);
				if (fin) begin
					emit = 1'b1;
					bad = 1'b1;
				end
			end
		end else begin
			broken_n = broken_q || (c[7:6] != 2'b00);
			gathered_n = {gathered_q[u8sd_pkg::CodeW-7:0], c[5:0]};
			pending_n = pending_q - u8sd_pkg::PEND_ONE;
			if (pending_n == u8sd_pkg::PEND_IDLE) begin
				emit = 1'b1;
				bad = broken_n;
				if (lead_q < u8sd_pkg::LEAD3_MIN) begin
					code = {10'b0, gathered_n[10:0]};
					if (code <= u8sd_pkg::MAX1) begin
						bad = 1'b1;
					end
				end else if (lead_q < u8sd_pkg::LEAD4_MIN) begin
					code = {5'b0, gathered_n[15:0]};
					if (code <= u8sd_pkg::MAX2) begin
						bad = 1'b1;
					end
				end else begin
					code = gathered_n;
					if (lead_q >= u8sd_pkg::LEAD_BAD_MIN || code <= u8sd_pkg::MAX3) begin
						bad = 1'b1;
					end
				end
			end else if (fin) begin
				emit = 1'b1;
				bad = 1'b1;
			end
		end
		if (emit && (fin || pending_n == u8sd_pkg::PEND_IDLE)) begin
			lead_n = '0;
			gathered_n = '0;
			pending_n = u8sd_pkg::PEND_IDLE;
			broken_n = 1'b0;
		end
		if (bad) begin
			code = '0;
		end
	end

	// input stage and decode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			lead_q <= '0;
			gathered_q <= '0;
			pending_q <= u8sd_pkg::PEND_IDLE;
			broken_q <= 1'b0;
		end else begin
			if (in.ready) begin
				valid_s1 <= in.valid;
			end
			if (valid_s1 && adv_s1) begin
				lead_q <= lead_n;
				gathered_q <= gathered_n;
				pending_q <= pending_n;
				broken_q <= broken_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in.valid && in.ready) begin
			item_s1 <= in.payload;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1 && emit) begin
			out_item_q.code_point <= code;
			out_item_q.bad_sequence <= bad;
			out_item_q.string_end <= fin;
		end
	end

	`U8SD_ASSERT_NOW(a_pend_has_lead, pending_q != u8sd_pkg::PEND_IDLE, lead_q >= u8sd_pkg::LEAD2_MIN, "group pending without a lead byte")
	`U8SD_ASSERT_NOW(a_four_byte_lead, pending_q == u8sd_pkg::PEND_THREE, lead_q >= u8sd_pkg::LEAD4_MIN, "three bytes pending on a short lead")
	`U8SD_ASSERT_NOW(a_idle_clean, pending_q == u8sd_pkg::PEND_IDLE, !broken_q, "error flag held while idle")
	`U8SD_ASSERT_NOW(a_bad_zero, out_valid_q && out_item_q.bad_sequence, out_item_q.code_point == '0, "error result carries a code")
	`U8SD_ASSERT_NEXT(a_final_idle, valid_s1 && adv_s1 && fin, pending_q == u8sd_pkg::PEND_IDLE, "decoder not idle after final byte")

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for utf8_stream_decoder: directed byte groups, then random text
// depends on u8sd_pkg, u8sd_chan_if and the decoder rtl
`timescale 1ns / 1ps

module tb;

	import u8sd_pkg::*;

	localparam int unsigned RUN_BYTES = 1700;
	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned DRAIN_CYCLES = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	u8sd_chan_if #(.payload_t(in_item_t)) in_ch ();
	u8sd_chan_if #(.payload_t(out_item_t)) out_ch ();

	utf8_stream_decoder i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in(in_ch),
		.out(out_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// decoder state mirror
	logic [ByteW-1:0] grp_lead;
	logic [CodeW-1:0] grp_bits;
	logic [PendW-1:0] grp_left;
	logic             grp_broken;

	out_item_t expected_codes[$];
	out_item_t got_item;
	out_item_t want_item;

	bit calm;
	int errors;
	int bytes_sent;
	int strings_sent;
	int results_checked;
	int malformed_seen;
	int stall_cycles;

	function automatic void reset_group();
		grp_lead = '0;
		grp_bits = '0;
		grp_left = PEND_IDLE;
		grp_broken = 1'b0;
	endfunction

	function automatic bit decode_byte(input in_item_t item, output out_item_t res);
		logic [ByteW-1:0] b;
		logic [ByteW-1:0] c;
		logic [CodeW-1:0] code;
		logic             bad;
		b = item.text_byte;
		res = '0;
		res.string_end = item.final_byte;
		if (grp_left == PEND_IDLE) begin
			if (b < CONT_MARK) begin
				res.code_point = CodeW'(b);
				return 1'b1;
			end
			if (b < LEAD2_MIN) begin
				res.bad_sequence = 1'b1;
				return 1'b1;
			end
			grp_lead = b;
			grp_bits = CodeW'(b);
			grp_left = (b < LEAD3_MIN) ? PEND_ONE : (b < LEAD4_MIN) ? PEND_TWO : PEND_THREE;
			grp_broken = (b >= LEAD_BAD_MIN);
			if (item.final_byte) begin
				reset_group();
				res.bad_sequence = 1'b1;
				return 1'b1;
			end
			return 1'b0;
		end
		c = b ^ CONT_MARK;
		if (c[7:6] != 2'b00)
			grp_broken = 1'b1;
		grp_bits = {grp_bits[CodeW-7:0], c[5:0]};
		grp_left = grp_left - PEND_ONE;
		if (grp_left == PEND_IDLE) begin
			bad = grp_broken;
			if (grp_lead < LEAD3_MIN) begin
				code = grp_bits & MAX2;
				if (code <= MAX1)
					bad = 1'b1;
			end else if (grp_lead < LEAD4_MIN) begin
				code = grp_bits & MAX3;
				if (code <= MAX2)
					bad = 1'b1;
			end else begin
				code = grp_bits;
				if (grp_lead >= LEAD_BAD_MIN || code <= MAX3)
					bad = 1'b1;
			end
			reset_group();
			res.bad_sequence = bad;
			res.code_point = bad ? '0 : code;
			return 1'b1;
		end
		if (item.final_byte) begin
			reset_group();
			res.bad_sequence = 1'b1;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic logic [CodeW-1:0] pick_code(input int unsigned len, input bit overlong);
		case (len)
			1: return CodeW'($urandom_range(MAX1));
			2: return overlong ? CodeW'($urandom_range(MAX1))
				: CodeW'($urandom_range(MAX2, MAX1 + 1));
			3: return overlong ? CodeW'($urandom_range(MAX2))
				: CodeW'($urandom_range(MAX3, MAX2 + 1));
			default: return overlong ? CodeW'($urandom_range(MAX3))
				: CodeW'($urandom_range(21'h1FFFFF, MAX3 + 1));
		endcase
	endfunction

	task automatic send_byte(input logic [ByteW-1:0] b, input bit fin);
		in_item_t  item;
		out_item_t res;
		item.text_byte = b;
		item.final_byte = fin;
		while (!calm && $urandom_range(99) < 33) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.payload <= item;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		bytes_sent++;
		if (fin)
			strings_sent++;
		if (decode_byte(item, res)) begin
			expected_codes.insert(expected_codes.size(), res);
			if (res.bad_sequence)
				malformed_seen++;
		end
	endtask

	// encode a code point, optionally corrupt one continuation and stop early
	task automatic send_group(input logic [CodeW-1:0] code, input int unsigned len,
			input int unsigned keep, input int unsigned spoil, input bit fin);
		logic [ByteW-1:0] seq [4];
		logic [1:0]       top;
		case (len)
			1: seq[0] = {1'b0, code[6:0]};
			2: begin
				seq[0] = {3'b110, code[10:6]};
				seq[1] = {2'b10, code[5:0]};
			end
			3: begin
				seq[0] = {4'b1110, code[15:12]};
				seq[1] = {2'b10, code[11:6]};
				seq[2] = {2'b10, code[5:0]};
			end
			default: begin
				seq[0] = {5'b11110, code[20:18]};
				seq[1] = {2'b10, code[17:12]};
				seq[2] = {2'b10, code[11:6]};
				seq[3] = {2'b10, code[5:0]};
			end
		endcase
		if (spoil != 0) begin
			top = 2'($urandom_range(2));
			if (top == 2'b10)
				top = 2'b11;
			seq[spoil] = {top, 6'($urandom)};
		end
		for (int i = 0; i < keep; i++)
			send_byte(seq[i], fin && i == keep - 1);
	endtask

	task automatic test_plain_bytes();
		send_byte(8'h00, 1'b0);
		send_byte(8'h7F, 1'b1);
		send_byte(8'hBF, 1'b0);
	endtask

	task automatic test_full_groups();
		send_group(21'h000800, 3, 3, 0, 1'b0);
		send_group(21'h1FFFFF, 4, 4, 0, 1'b1);
	endtask

	task automatic test_overlong();
		send_group(MAX1, 2, 2, 0, 1'b0);
		send_group(MAX2, 3, 3, 0, 1'b0);
		send_group(MAX3, 4, 4, 0, 1'b0);
	endtask

	task automatic test_bad_lead();
		send_byte(8'hFF, 1'b0);
		repeat (3)
			send_byte(CONT_MARK, 1'b0);
	endtask

	task automatic test_bad_continuation();
		send_group(21'h000080, 2, 2, 1, 1'b0);
	endtask

	task automatic test_cut_short();
		send_group(21'h0000C3, 2, 1, 0, 1'b1);
		send_group(21'h010000, 4, 3, 0, 1'b1);
	endtask

	task automatic test_random_text();
		int unsigned pick;
		int unsigned len;
		bit          fin;
		while (bytes_sent < RUN_BYTES) begin
			calm = (bytes_sent >= 700 && bytes_sent < 1000);
			pick = $urandom_range(99);
			fin = ($urandom_range(7) == 0);
			if (pick < 70) begin
				len = $urandom_range(4, 1);
				send_group(pick_code(len, 1'b0), len, len, 0, fin);
			end else if (pick < 78) begin
				len = $urandom_range(4, 2);
				send_group(pick_code(len, 1'b1), len, len, 0, fin);
			end else if (pick < 86) begin
				len = $urandom_range(4, 2);
				send_group(pick_code(len, 1'b0), len, $urandom_range(len - 1, 1), 0, 1'b1);
			end else if (pick < 93) begin
				len = $urandom_range(4, 2);
				send_group(pick_code(len, 1'b0), len, len, $urandom_range(len - 1, 1), fin);
			end else begin
				send_byte(8'($urandom), 1'($urandom_range(1)));
			end
		end
		calm = 1'b0;
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got_item = out_ch.payload;
			results_checked++;
			if (expected_codes.size() == 0) begin
				$display("%0t: unexpected result, expected none, got code %h bad %b end %b",
					$time, got_item.code_point, got_item.bad_sequence, got_item.string_end);
				errors++;
			end else begin
				want_item = expected_codes.pop_front();
				if (got_item.code_point !== want_item.code_point) begin
					$display("%0t: code_point expected %h got %h",
						$time, want_item.code_point, got_item.code_point);
					errors++;
				end
				if (got_item.bad_sequence !== want_item.bad_sequence) begin
					$display("%0t: bad_sequence expected %b got %b",
						$time, want_item.bad_sequence, got_item.bad_sequence);
					errors++;
				end
				if (got_item.string_end !== want_item.string_end) begin
					$display("%0t: string_end expected %b got %b",
						$time, want_item.string_end, got_item.string_end);
					errors++;
				end
			end
		end
		out_ch.ready <= calm || $urandom_range(99) >= 33;
	end

	// watchdog on handshake activity
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no request moved for %0d cycles", $time, stall_cycles);
			$display("tb: errors");
			$finish;
		end
	end

	initial begin
		in_ch.valid <= 1'b0;
		in_ch.payload <= '0;
		reset_group();
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_plain_bytes();
		test_full_groups();
		test_overlong();
		test_bad_lead();
		test_bad_continuation();
		test_cut_short();
		test_random_text();

		in_ch.valid <= 1'b0;
		while (expected_codes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		$display("summary: %0d bytes over %0d terminated strings decoded", bytes_sent, strings_sent);
		$display("summary: %0d results checked, %0d of them malformed groups",
			results_checked, malformed_seen);
		if (errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+design
design/u8sd_pkg.sv
design/u8sd_chan_if.sv
design/utf8_stream_decoder.sv
tb/tb.sv
